/* src/dual_joystick_debounce_reporter_macros.svh */
// assertion macros shared by the checker of the joystick reporter
// no dependencies; the including file must provide i_clk and i_rst_n
`ifndef DUAL_JOYSTICK_DEBOUNCE_REPORTER_MACROS_SVH
`define DUAL_JOYSTICK_DEBOUNCE_REPORTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DJDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("djdr assertion failed");

// next-cycle implication, disabled while in reset
`define DJDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("djdr assertion failed");

`endif

/* src/djdr_pkg.sv */
// shared constants, types and hat encoder of the joystick reporter
// no dependencies
package djdr_pkg;

    localparam int PIN_COUNT  = 10;
    localparam int PIN_IDX_W  = $clog2(PIN_COUNT);
    localparam int PORT_PINS  = 10;
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 22;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(20 * 1000);
    localparam logic [DEBOUNCE_W-1:0] MAX_LOCKOUT    = DEBOUNCE_W'(2500 * 1000);

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;

    localparam logic [3:0] HAT_CENTER = 4'd0;
    localparam logic [3:0] HAT_N      = 4'd1;
    localparam logic [3:0] HAT_NE     = 4'd2;
    localparam logic [3:0] HAT_E      = 4'd3;
    localparam logic [3:0] HAT_SE     = 4'd4;
    localparam logic [3:0] HAT_S      = 4'd5;
    localparam logic [3:0] HAT_SW     = 4'd6;
    localparam logic [3:0] HAT_W      = 4'd7;
    localparam logic [3:0] HAT_NW     = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [3:0] dir;
        logic       button;
    } t_report;

    // pins: up, down, left, right, button
    function automatic t_report make_report(input logic [4:0] pins);
        t_report rep;
        rep.button = pins[4];
        if (pins[0]) begin
            rep.dir = pins[3] ? HAT_NE : (pins[2] ? HAT_NW : HAT_N);
        end else if (pins[1]) begin
            rep.dir = pins[3] ? HAT_SE : (pins[2] ? HAT_SW : HAT_S);
        end else if (pins[3]) begin
            rep.dir = HAT_E;
        end else if (pins[2]) begin
            rep.dir = HAT_W;
        end else begin
            rep.dir = HAT_CENTER;
        end
        return rep;
    endfunction

endpackage

/* src/djdr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module djdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dual_joystick_debounce_reporter.sv */
// top level of the dual joystick debounce and hat reporter
// depends on djdr_pkg and djdr_ram
//
// usage
// - input channel (i_valid/o_ready): one word per pin sample with the
//   microsecond timestamp, the ten active-low pin levels and the host
//   ready flag of each report channel
// - output channel (o_valid/i_ready): exactly one word per input word, in
//   order: send flag, hat code and button per joystick, and the debounced
//   pressed pins after the sample
// - apb port: register 0 (byte 0) is debounce_us, lockout in us, clipped
//   to 2.5 s when used; pready is tied high
// - lockout deadlines live in a small ram, one entry per pin; the engine
//   sweeps it one pin per cycle (read, then compare and write back)
// - the sweep is bound by the single read port of the deadline ram; a new
//   word starts only once the previous sweep is done
// - a one-word input buffer takes the next sample while the engine works,
//   and the output register holds a finished word while the next is swept
// - a stalled receiver holds the engine in its final state until the
//   output register frees; the input buffer then fills and o_ready drops
// - reset: nothing pressed, no lockout (per-pin valid bits), reports
//   center and released, debounce_us back to 20000; no clearing pass
module dual_joystick_debounce_reporter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [djdr_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [djdr_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [djdr_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // input words
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [djdr_pkg::TIME_W-1:0]           i_now_us,
    input  logic [djdr_pkg::PORT_PINS-1:0]        i_pins_low,
    input  logic                                  i_ready_one,
    input  logic                                  i_ready_two,
    // output words
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_send_one,
    output logic [3:0]                            o_direction_one,
    output logic                                  o_button_one,
    output logic                                  o_send_two,
    output logic [3:0]                            o_direction_two,
    output logic                                  o_button_two,
    output logic [djdr_pkg::PORT_PINS-1:0]        o_pressed_pins
);

    localparam int NP = djdr_pkg::PIN_COUNT;
    localparam int IW = djdr_pkg::PIN_IDX_W;
    localparam int TW = djdr_pkg::TIME_W;
    localparam int DW = djdr_pkg::DEBOUNCE_W;
    localparam int PP = djdr_pkg::PORT_PINS;

    // ---------------- configuration register ----------------
    localparam int CFG_IDX_BIT = 2;

    logic [DW-1:0] r_debounce;
    logic [DW-1:0] r_lock;      // clipped copy used by the engine
    logic          w_cfg_hit;
    logic          w_cfg_wr;

    assign w_cfg_hit = (paddr[CFG_IDX_BIT] == djdr_pkg::REG_DEBOUNCE);
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_hit;
    assign pready    = 1'b1;
    assign prdata    = w_cfg_hit ? djdr_pkg::CFG_DATA_W'(r_debounce) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= djdr_pkg::DEBOUNCE_RESET;
            r_lock     <= djdr_pkg::DEBOUNCE_RESET;
        end else if (w_cfg_wr) begin
            r_debounce <= pwdata[DW-1:0];
            r_lock     <= (pwdata[DW-1:0] > djdr_pkg::MAX_LOCKOUT) ?
                          djdr_pkg::MAX_LOCKOUT : pwdata[DW-1:0];
        end
    end

    // ---------------- input buffer ----------------
    logic          r_buf_full;
    logic [TW-1:0] r_buf_now;
    logic [NP-1:0] r_buf_samp;
    logic          r_buf_rdy1;
    logic          r_buf_rdy2;
    logic [NP-1:0] w_sampled;
    logic          w_in_acc;
    logic          w_start;

    // active-low pins to pressed levels; pins beyond the port read released
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            w_sampled[i] = (i < PP) ? ~i_pins_low[i % PP] : 1'b0;
        end
    end

    assign o_ready  = !r_buf_full;
    assign w_in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_full <= 1'b0;
        end else if (w_in_acc) begin
            r_buf_full <= 1'b1;
        end else if (w_start) begin
            r_buf_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_buf_now  <= i_now_us;
            r_buf_samp <= w_sampled;
            r_buf_rdy1 <= i_ready_one;
            r_buf_rdy2 <= i_ready_two;
        end
    end

    // ---------------- sweep engine ----------------
    djdr_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_idx;
    logic          r_wb_v;
    logic [IW-1:0] r_wb_idx;
    logic [TW-1:0] r_now;
    logic [NP-1:0] r_samp;
    logic          r_rdy1;
    logic          r_rdy2;
    logic [NP-1:0] r_pressed, n_pressed;
    logic [NP-1:0] r_dl_valid;   // entry written since reset
    logic          r_out_valid;
    logic          w_out_load;
    logic          w_last;
    logic          w_ram_re;
    logic [TW-1:0] w_rdata;
    logic [TW-1:0] w_deadline;
    logic [TW-1:0] w_remain;
    logic          w_over;
    logic          w_flip;
    logic [TW-1:0] w_new_dl;

    assign w_last     = (r_idx == IW'(NP - 1));
    assign w_out_load = (r_state == djdr_pkg::ST_DONE) && (!r_out_valid || i_ready);
    assign w_start    = r_buf_full &&
                        ((r_state == djdr_pkg::ST_IDLE) || w_out_load);
    assign w_ram_re   = (r_state == djdr_pkg::ST_RUN);

    always_comb begin
        n_state = r_state;
        case (r_state)
            djdr_pkg::ST_IDLE: begin
                if (w_start) n_state = djdr_pkg::ST_RUN;
            end
            djdr_pkg::ST_RUN: begin
                if (w_last) n_state = djdr_pkg::ST_DONE;
            end
            djdr_pkg::ST_DONE: begin
                if (w_out_load) n_state = w_start ? djdr_pkg::ST_RUN : djdr_pkg::ST_IDLE;
            end
            default: n_state = djdr_pkg::ST_IDLE;
        endcase
    end

    // writeback stage: deadline of pin r_wb_idx arrives from the ram
    assign w_deadline = r_dl_valid[r_wb_idx] ? w_rdata : '0;
    assign w_remain   = w_deadline - r_now;
    assign w_over     = (w_deadline == '0) || (w_remain > TW'(djdr_pkg::MAX_LOCKOUT));
    assign w_flip     = r_wb_v && (r_samp[r_wb_idx] ^ r_pressed[r_wb_idx]) && w_over;
    assign w_new_dl   = (r_now + TW'(r_lock)) | TW'(1);

    always_comb begin
        n_pressed = r_pressed;
        if (w_flip) n_pressed[r_wb_idx] = ~r_pressed[r_wb_idx];
    end

    djdr_ram #(
        .WIDTH (TW),
        .DEPTH (NP)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (w_flip),
        .i_waddr (r_wb_idx),
        .i_wdata (w_new_dl),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= djdr_pkg::ST_IDLE;
            r_idx      <= '0;
            r_wb_v     <= 1'b0;
            r_pressed  <= '0;
            r_dl_valid <= '0;
        end else begin
            r_state   <= n_state;
            r_wb_v    <= w_ram_re;
            r_pressed <= n_pressed;
            if (w_flip) r_dl_valid[r_wb_idx] <= 1'b1;
            if (w_start) begin
                r_idx <= '0;
            end else if (w_ram_re && !w_last) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_idx;
        if (w_start) begin
            r_now  <= r_buf_now;
            r_samp <= r_buf_samp;
            r_rdy1 <= r_buf_rdy1;
            r_rdy2 <= r_buf_rdy2;
        end
    end

    // ---------------- report and output register ----------------
    logic [PP-1:0]     w_pad;
    djdr_pkg::t_report w_rep1, w_rep2;
    djdr_pkg::t_report r_sent1, r_sent2;
    logic              w_send1, w_send2;

    // pressed state on the port's ten bits; the last writeback is included
    always_comb begin
        for (int j = 0; j < PP; j++) begin
            w_pad[j] = (j < NP) ? n_pressed[j % NP] : 1'b0;
        end
    end

    assign w_rep1  = djdr_pkg::make_report(w_pad[4:0]);
    assign w_rep2  = djdr_pkg::make_report(w_pad[9:5]);
    assign w_send1 = (w_rep1 != r_sent1) && r_rdy1;
    assign w_send2 = (w_rep2 != r_sent2) && r_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sent1     <= '0;
            r_sent2     <= '0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
            if (w_send1) r_sent1 <= w_rep1;
            if (w_send2) r_sent2 <= w_rep2;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_send_one      <= w_send1;
            o_direction_one <= w_rep1.dir;
            o_button_one    <= w_rep1.button;
            o_send_two      <= w_send2;
            o_direction_two <= w_rep2.dir;
            o_button_two    <= w_rep2.button;
            o_pressed_pins  <= w_pad;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* src/djdr_checker.sv */
// port-level checker of the joystick reporter, bound to the top level
// depends on dual_joystick_debounce_reporter_macros.svh
`include "dual_joystick_debounce_reporter_macros.svh"

module djdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_send_one,
    input logic [3:0] o_direction_one,
    input logic       o_button_one,
    input logic       o_send_two,
    input logic [3:0] o_direction_two,
    input logic       o_button_two,
    input logic [9:0] o_pressed_pins
);

    // a stalled word stays
    `DJDR_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `DJDR_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable({o_send_one, o_direction_one, o_button_one, o_send_two, o_direction_two, o_button_two, o_pressed_pins}))

    // hat code and button agree with the debounced pins of each joystick
    `DJDR_ASSERT_NOW(a_hat_one, o_valid, ((o_direction_one == 4'd0) == (o_pressed_pins[3:0] == 4'd0)) && (o_button_one == o_pressed_pins[4]) && (o_direction_one <= 4'd8))
    `DJDR_ASSERT_NOW(a_hat_two, o_valid, ((o_direction_two == 4'd0) == (o_pressed_pins[8:5] == 4'd0)) && (o_button_two == o_pressed_pins[9]) && (o_direction_two <= 4'd8))

endmodule

bind dual_joystick_debounce_reporter djdr_checker u_djdr_checker (.*);

/* tb/tb_dual_joystick_debounce_reporter.sv */
// self-checking testbench of the dual joystick debounce and hat reporter
// drives pin samples and apb writes, predicts every report word in place
// depends on djdr_pkg and dual_joystick_debounce_reporter
`timescale 1ns / 1ps

module tb_dual_joystick_debounce_reporter;

    localparam int TW = djdr_pkg::TIME_W;
    localparam int PP = djdr_pkg::PORT_PINS;
    localparam int NP = djdr_pkg::PIN_COUNT;
    localparam int DW = djdr_pkg::DEBOUNCE_W;
    localparam int AW = djdr_pkg::CFG_ADDR_W;
    localparam int CW = djdr_pkg::CFG_DATA_W;

    // run control
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 210;

    // register index with nothing behind it, writes there must be ignored
    localparam logic REG_SPARE = 1'b1;

    // joystick pin masks within one five-pin group
    localparam logic [4:0] PIN_UP    = 5'b00001;
    localparam logic [4:0] PIN_DOWN  = 5'b00010;
    localparam logic [4:0] PIN_LEFT  = 5'b00100;
    localparam logic [4:0] PIN_RIGHT = 5'b01000;
    localparam logic [4:0] PIN_BTN   = 5'b10000;

    typedef struct {
        bit [TW-1:0] now_us;
        bit [PP-1:0] pins_low;
        bit          ready_one;
        bit          ready_two;
    } t_pin_sample;

    typedef struct {
        bit          send_one;
        bit [3:0]    direction_one;
        bit          button_one;
        bit          send_two;
        bit [3:0]    direction_two;
        bit          button_two;
        bit [PP-1:0] pressed_pins;
    } t_report_word;

    // clock, reset and every block input start at known values
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [AW-1:0]           paddr       = '0;
    logic [CW-1:0]           pwdata      = '0;
    logic [CW-1:0]           prdata;
    logic                    pready;
    logic                    i_valid     = 1'b0;
    logic                    o_ready;
    logic [TW-1:0]           i_now_us    = '0;
    logic [PP-1:0]           i_pins_low  = '1;
    logic                    i_ready_one = 1'b0;
    logic                    i_ready_two = 1'b0;
    logic                    o_valid;
    logic                    i_ready     = 1'b0;
    logic                    o_send_one;
    logic [3:0]              o_direction_one;
    logic                    o_button_one;
    logic                    o_send_two;
    logic [3:0]              o_direction_two;
    logic                    o_button_two;
    logic [PP-1:0]           o_pressed_pins;

    dual_joystick_debounce_reporter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_now_us        (i_now_us),
        .i_pins_low      (i_pins_low),
        .i_ready_one     (i_ready_one),
        .i_ready_two     (i_ready_two),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_send_one      (o_send_one),
        .o_direction_one (o_direction_one),
        .o_button_one    (o_button_one),
        .o_send_two      (o_send_two),
        .o_direction_two (o_direction_two),
        .o_button_two    (o_button_two),
        .o_pressed_pins  (o_pressed_pins)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: debounced pins, per-pin lockout deadlines, the
    // report last sent on each channel and the debounce register
    // ------------------------------------------------------------------
    bit [PP-1:0] debounced_pins   = '0;
    bit [TW-1:0] pin_deadline [NP];
    bit [4:0]    sent_one         = '0;
    bit [4:0]    sent_two         = '0;
    bit [DW-1:0] debounce_setting = djdr_pkg::DEBOUNCE_RESET;

    t_pin_sample  pending_samples [$];
    t_report_word expected_reports [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // stimulus generator state, carries time and pin levels across words
    bit [TW-1:0] stim_now  = '0;
    bit [PP-1:0] stim_pins = '1;

    initial begin
        foreach (pin_deadline[k]) pin_deadline[k] = '0;
    end

    // lockout actually applied: register value clipped to 2.5 s
    function automatic bit [DW-1:0] effective_lockout();
        return (debounce_setting > djdr_pkg::MAX_LOCKOUT) ?
               djdr_pkg::MAX_LOCKOUT : debounce_setting;
    endfunction

    // five pins up, down, left, right, button -> {button, hat code}
    // up beats down and right beats left
    function automatic bit [4:0] joystick_report(input bit [4:0] p);
        bit       north;
        bit       south;
        bit       east;
        bit       west;
        bit [3:0] hat;
        north = p[0];
        south = p[1] & ~p[0];
        east  = p[3];
        west  = p[2] & ~p[3];
        case ({north, south, east, west})
            4'b1000: hat = djdr_pkg::HAT_N;
            4'b1010: hat = djdr_pkg::HAT_NE;
            4'b0010: hat = djdr_pkg::HAT_E;
            4'b0110: hat = djdr_pkg::HAT_SE;
            4'b0100: hat = djdr_pkg::HAT_S;
            4'b0101: hat = djdr_pkg::HAT_SW;
            4'b0001: hat = djdr_pkg::HAT_W;
            4'b1001: hat = djdr_pkg::HAT_NW;
            default: hat = djdr_pkg::HAT_CENTER;
        endcase
        return {p[4], hat};
    endfunction

    // advance the predictor by one accepted sample, return the report word
    function automatic t_report_word debounce_and_report(input t_pin_sample s);
        t_report_word w;
        bit [PP-1:0]  sampled;
        bit [TW-1:0]  remaining;
        bit [4:0]     rep_one;
        bit [4:0]     rep_two;
        sampled = ~s.pins_low;
        for (int i = NP; i < PP; i++) sampled[i] = 1'b0;
        for (int i = 0; i < NP; i++) begin
            // wrapped distance to the deadline; beyond 2.5 s means it has passed
            remaining = pin_deadline[i] - s.now_us;
            if (sampled[i] != debounced_pins[i] &&
                (pin_deadline[i] == '0 || remaining > TW'(djdr_pkg::MAX_LOCKOUT))) begin
                debounced_pins[i] = sampled[i];
                pin_deadline[i]   = (s.now_us + TW'(effective_lockout())) | TW'(1);
            end
        end
        rep_one = joystick_report(debounced_pins[4:0]);
        rep_two = joystick_report(debounced_pins[9:5]);
        // a report goes out only on change and with the host ready
        w.send_one = (rep_one != sent_one) && s.ready_one;
        w.send_two = (rep_two != sent_two) && s.ready_two;
        if (w.send_one) sent_one = rep_one;
        if (w.send_two) sent_two = rep_two;
        w.direction_one = rep_one[3:0];
        w.button_one    = rep_one[4];
        w.direction_two = rep_two[3:0];
        w.button_two    = rep_two[4];
        w.pressed_pins  = debounced_pins;
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor and acceptance: output words are checked first, then an
    // input word taken at this edge is run through the predictor
    // ------------------------------------------------------------------
    logic in_fire = 1'b0;

    always @(posedge i_clk) begin
        t_report_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $error("report word with no pending expectation");
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("send_one",      want.send_one,      o_send_one);
                check_field("direction_one", want.direction_one, o_direction_one);
                check_field("button_one",    want.button_one,    o_button_one);
                check_field("send_two",      want.send_two,      o_send_two);
                check_field("direction_two", want.direction_two, o_direction_two);
                check_field("button_two",    want.button_two,    o_button_two);
                check_field("pressed_pins",  want.pressed_pins,  o_pressed_pins);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            expected_reports.push_back(debounce_and_report('{i_now_us, i_pins_low,
                                                            i_ready_one, i_ready_two}));
        end
        in_fire <= i_rst_n && i_valid && o_ready;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sample driver: bursts of random length, random gaps in between,
    // many bursts with no gap at all; a word holds until it is taken
    // ------------------------------------------------------------------
    int          burst_left = 1;
    int          gap_left   = 0;
    t_pin_sample next_sample;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            // word still on offer, keep everything steady
        end else if (gap_left > 0) begin
            i_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_samples.size() > 0) begin
            next_sample  = pending_samples.pop_front();
            i_now_us    <= next_sample.now_us;
            i_pins_low  <= next_sample.pins_low;
            i_ready_one <= next_sample.ready_one;
            i_ready_two <= next_sample.ready_two;
            i_valid     <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // report receiver: rcv_cycle[8:7] picks the stall pattern among
    // always ready, a fixed toggle, coin flips and mostly stalled; a
    // requested hold-off keeps it stalled long enough to back up the block
    // ------------------------------------------------------------------
    bit [31:0] rcv_cycle     = '0;
    int        hold_left     = 0;
    int        hold_requests = 0;
    int        holds_served  = 0;

    always @(negedge i_clk) begin
        rcv_cycle <= rcv_cycle + 1;
        if (holds_served < hold_requests && hold_left == 0) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
            i_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            case (rcv_cycle[8:7])
                2'd0:    i_ready <= 1'b1;
                2'd1:    i_ready <= rcv_cycle[1] ^ rcv_cycle[3];
                2'd2:    i_ready <= ($urandom_range(0, 1) != 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // active-low port levels for given pressed pins of each joystick
    function automatic bit [PP-1:0] pins_for(input bit [4:0] j1, input bit [4:0] j2);
        return ~{j2, j1};
    endfunction

    task automatic add_sample(input bit [TW-1:0] now, input bit [PP-1:0] pins,
                              input bit r1, input bit r2);
        stim_now  = now;
        stim_pins = pins;
        pending_samples.push_back('{now, pins, r1, r2});
    endtask

    // random words: time steps cluster below, around and past the lockout,
    // with rare large jumps; pins mostly flip one or two bits at a time
    task automatic add_random_samples(input int count);
        bit [TW-1:0] lock;
        int          pick;
        for (int n = 0; n < count; n++) begin
            lock = TW'(effective_lockout());
            pick = $urandom_range(0, 99);
            if (pick < 30)      stim_now += $urandom_range(0, 300);
            else if (pick < 55) stim_now += lock + $urandom_range(0, 60) - 32'd30;
            else if (pick < 85) stim_now += lock + $urandom_range(1, 50000);
            else if (pick < 95) stim_now += $urandom_range(0, 5000000);
            else                stim_now  = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                repeat ($urandom_range(1, 2)) stim_pins[$urandom_range(0, PP-1)] ^= 1'b1;
            end else if (pick < 85) begin
                stim_pins = PP'($urandom());
            end
            pending_samples.push_back('{stim_now, stim_pins,
                                        $urandom_range(0, 4) != 0,
                                        $urandom_range(0, 4) != 0});
        end
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_register(input logic idx, input bit [CW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == djdr_pkg::REG_DEBOUNCE) debounce_setting = value[DW-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block idle: nothing queued, nothing on offer, every report back
    task automatic wait_idle();
        while (pending_samples.size() != 0 || i_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        bit [TW-1:0] t_odd;
        bit [TW-1:0] t_even;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lockout of 20 ms: every hat code, priorities, host not ready,
        // lockout suppression and a deadline across the time wrap
        add_sample(32'd1000,   pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(32'd51000,  pins_for(PIN_UP, PIN_DOWN | PIN_LEFT | PIN_BTN), 1'b1, 1'b1);
        add_sample(32'd51050,  pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(32'd101000, pins_for(PIN_UP | PIN_RIGHT, PIN_DOWN | PIN_RIGHT), 1'b1, 1'b1);
        add_sample(32'd151000, pins_for(PIN_RIGHT, PIN_DOWN), 1'b0, 1'b1);
        add_sample(32'd151100, pins_for(PIN_RIGHT, PIN_DOWN), 1'b1, 1'b1);
        add_sample(32'd201000, pins_for(PIN_LEFT, PIN_UP | PIN_LEFT), 1'b1, 1'b0);
        add_sample(32'd201100, pins_for(PIN_LEFT, PIN_UP | PIN_LEFT), 1'b1, 1'b1);
        add_sample(32'd251000, pins_for(5'h1F, PIN_UP | PIN_DOWN), 1'b1, 1'b1);
        add_sample(32'd301000, pins_for(PIN_LEFT | PIN_RIGHT, 5'd0), 1'b1, 1'b1);
        add_sample(32'd351000, pins_for(5'h1F, 5'h1F), 1'b1, 1'b1);
        add_sample(32'd401000, pins_for(5'd0, 5'd0), 1'b0, 1'b0);
        add_sample(32'd401100, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(32'hFFFF_FFF0, pins_for(PIN_BTN, 5'd0), 1'b1, 1'b1);
        add_sample(32'h0000_4000, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(32'h0000_5000, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_random_samples(RANDOM_WORDS);
        wait_idle();

        // zero debounce setting, the deadline is the sample time made odd; long receiver stall
        write_register(djdr_pkg::REG_DEBOUNCE, 32'd0);
        @(posedge i_clk);
        add_random_samples(RANDOM_WORDS);
        hold_requests++;
        wait_idle();

        // all ones: the upper bits drop and the 22-bit value clips to 2.5 s
        write_register(djdr_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF);
        @(posedge i_clk);
        add_random_samples(RANDOM_WORDS);
        wait_idle();

        // exactly 2.5 s: deadline right at the limit from an odd time (held)
        // and one past it from an even time (released at once)
        write_register(djdr_pkg::REG_DEBOUNCE, 32'd2_500_000);
        @(posedge i_clk);
        t_odd  = (stim_now + 32'd6_000_000) | 32'd1;
        t_even = t_odd + 32'd6_000_001;
        add_sample(stim_now + 32'd5, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(t_odd,                 pins_for(PIN_UP, 5'd0), 1'b1, 1'b1);
        add_sample(t_odd,                 pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(t_odd + 32'd2_500_000, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(t_odd + 32'd2_500_001, pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_sample(t_even,                pins_for(PIN_UP, 5'd0), 1'b1, 1'b1);
        add_sample(t_even,                pins_for(5'd0, 5'd0), 1'b1, 1'b1);
        add_random_samples(RANDOM_WORDS);
        wait_idle();

        // spare address must leave the lockout untouched, then a 1 us lockout
        write_register(REG_SPARE, 32'd777);
        write_register(djdr_pkg::REG_DEBOUNCE, 32'd1);
        @(posedge i_clk);
        add_random_samples(RANDOM_WORDS);
        hold_requests++;
        wait_idle();

        // back to the reset value by a write
        write_register(djdr_pkg::REG_DEBOUNCE, 32'(djdr_pkg::DEBOUNCE_RESET));
        @(posedge i_clk);
        add_random_samples(RANDOM_WORDS);
        wait_idle();

        // arbitrary lockout, sometimes above the clip point
        write_register(djdr_pkg::REG_DEBOUNCE, $urandom_range(0, 3_000_000));
        @(posedge i_clk);
        add_random_samples(RANDOM_WORDS);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
